// ----- rtl/kdt_pkg.sv -----
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared codes and constants of the k-mer dictionary tokenizer.
// ----------------------------------------------------------------------------
package kdt_pkg;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_LEARN  = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Field widths fixed by the interface.
    localparam int TOKEN_W  = 13;
    localparam int SYMBOL_W = 8;
    localparam int LEN_W    = 4;

    // Configuration port.
    localparam int          APB_AW       = 3;
    localparam int          APB_DW       = 32;
    localparam logic        REG_KMER_LEN = 1'b0;
    localparam logic [LEN_W-1:0] KMER_LEN_RESET = 4'd4;

    // Special result values.
    localparam logic [SYMBOL_W-1:0] BAD_CHAR   = 8'h3F;
    localparam logic [TOKEN_W-1:0]  UNKNOWN_ID = 13'h1FFF;

endpackage

// ----- rtl/kdt_ram.sv -----
// ----------------------------------------------------------------------------
// kdt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/kdt_cell.sv -----
// ----------------------------------------------------------------------------
// kdt_cell
// One search cell: owns one bank of the vocabulary, checks the row carried
// by the passing token and hands the merged token to the next cell.
// ----------------------------------------------------------------------------
module kdt_cell #(
    parameter int CELL_IDX   = 0,
    parameter int CELL_BITS  = 4,
    parameter int BANK_DEPTH = 256,
    parameter int RW         = 8,
    parameter int IW         = 12,
    parameter int CW         = 13,
    parameter int KW         = 64,
    parameter int TOK_W      = 1 + RW + 1 + IW + KW,
    parameter int CTRL_W     = 1 + KW + IW + CW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CTRL_W-1:0] i_ctrl,
    input  logic [TOK_W-1:0]  i_tok,
    input  logic              i_wr_en,
    input  logic [RW-1:0]     i_wr_row,
    input  logic [KW-1:0]     i_wr_data,
    output logic [TOK_W-1:0]  o_tok
);

    localparam int XW = (CW > IW) ? CW : IW;

    typedef struct packed {
        logic          active;
        logic [RW-1:0] row;
        logic          found;
        logic [IW-1:0] id;
        logic [KW-1:0] data;
    } t_tok;

    typedef struct packed {
        logic          decode;
        logic [KW-1:0] key;
        logic [IW-1:0] target;
        logic [CW-1:0] count;
    } t_ctrl;

    t_tok          w_tok_in;
    t_tok          w_tok_out;
    t_ctrl         w_ctrl;
    t_tok          r_tok;
    logic [KW-1:0] w_rd_data;
    logic [IW-1:0] w_my_id;
    logic          w_in_range;
    logic          w_match;
    logic          w_hit;

    assign w_tok_in = t_tok'(i_tok);
    assign w_ctrl   = t_ctrl'(i_ctrl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= w_tok_in.active;
        end
        r_tok.row   <= w_tok_in.row;
        r_tok.found <= w_tok_in.found;
        r_tok.id    <= w_tok_in.id;
        r_tok.data  <= w_tok_in.data;
    end

    kdt_ram #(
        .WIDTH (KW),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_row),
        .i_wr_data (i_wr_data),
        .i_rd_addr (w_tok_in.row),
        .o_rd_data (w_rd_data)
    );

    // Entry ids interleave across the cells: id = row * cells + cell index.
    assign w_my_id    = {r_tok.row, CELL_BITS'(CELL_IDX)};
    assign w_in_range = XW'(w_my_id) < XW'(w_ctrl.count);
    assign w_match    = w_ctrl.decode ? (w_my_id == w_ctrl.target)
                                      : (w_rd_data == w_ctrl.key);
    assign w_hit      = r_tok.active && w_in_range && w_match;

    // An earlier cell's hit has the lower id within the row, so it wins.
    always_comb begin
        w_tok_out        = r_tok;
        w_tok_out.found  = r_tok.found || w_hit;
        if (!r_tok.found) begin
            w_tok_out.id   = w_my_id;
            w_tok_out.data = w_rd_data;
        end
    end

    assign o_tok = TOK_W'(w_tok_out);

endmodule

// ----- rtl/kmer_dictionary_tokenizer.sv -----
// ----------------------------------------------------------------------------
// kmer_dictionary_tokenizer
// K-mer vocabulary with learn, encode and decode operations.
// ----------------------------------------------------------------------------
// A character that does not complete a k-mer is gathered into the buffer
// and the input stays ready. A completed k-mer is searched by a chain of
// 2**CELL_BITS cells (16 with the default), each owning one bank of the
// vocabulary; one row of all banks enters the chain per cycle.
// A decode walks the row of its id through the chain (no row for an id out
// of range) and then gives one result per cycle while the output is free,
// kmer_len in all. Input is taken again once the item is finished; a result
// may still wait in the output register meanwhile.
// The vocabulary needs no clearing after reset: entries at or above the
// stored count are never matched.
// ----------------------------------------------------------------------------
module kmer_dictionary_tokenizer #(
    parameter int VOCAB_DEPTH = 4096,
    parameter int KMER_MAX    = 8,
    parameter int CELL_BITS   = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_op,
    input  logic [kdt_pkg::SYMBOL_W-1:0]          i_symbol,
    input  logic                                  i_end_of_sequence,
    input  logic signed [kdt_pkg::TOKEN_W-1:0]    i_token_id,
    // Output channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [kdt_pkg::TOKEN_W-1:0]    o_out_token_id,
    output logic [kdt_pkg::SYMBOL_W-1:0]          o_out_symbol,
    output logic                                  o_last,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [kdt_pkg::APB_AW-1:0]            paddr,
    input  logic [kdt_pkg::APB_DW-1:0]            pwdata,
    output logic [kdt_pkg::APB_DW-1:0]            prdata,
    output logic                                  pready
);

    localparam int N          = 1 << CELL_BITS;
    localparam int BANK_DEPTH = (VOCAB_DEPTH + N - 1) / N;
    localparam int RW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int IW         = RW + CELL_BITS;
    localparam int CW         = $clog2(VOCAB_DEPTH + 1);
    localparam int KW         = 8 * KMER_MAX;
    localparam int FW         = $clog2(KMER_MAX + 1);
    localparam int XT         = (CW > 12) ? CW : 12;
    localparam int NW         = RW + 1;
    localparam int SW         = CW + CELL_BITS + 1;
    localparam int TOK_W      = 1 + RW + 1 + IW + KW;
    localparam int CTRL_W     = 1 + KW + IW + CW;
    localparam int LW         = kdt_pkg::LEN_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    typedef struct packed {
        logic          active;
        logic [RW-1:0] row;
        logic          found;
        logic [IW-1:0] id;
        logic [KW-1:0] data;
    } t_tok;

    typedef struct packed {
        logic          decode;
        logic [KW-1:0] key;
        logic [IW-1:0] target;
        logic [CW-1:0] count;
    } t_ctrl;

    // Configuration and gathering state
    logic [LW-1:0] r_kmer_len;
    logic [KW-1:0] r_buf;
    logic [FW-1:0] r_fill;
    logic [CW-1:0] r_count;
    logic [1:0]    r_state;

    // Current item
    logic          r_decode;
    logic          r_learn;
    logic          r_eos;
    logic [KW-1:0] r_key;
    logic [IW-1:0] r_target;
    logic [NW-1:0] r_rows;
    logic [NW-1:0] r_inj;
    logic [NW-1:0] r_done;
    logic          r_found;
    logic [IW-1:0] r_fid;
    logic [KW-1:0] r_fdata;
    logic [FW-1:0] r_emit_idx;

    // Output register
    logic                         r_out_valid;
    logic [kdt_pkg::TOKEN_W-1:0]  r_out_token_id;
    logic [kdt_pkg::SYMBOL_W-1:0] r_out_symbol;
    logic                         r_out_last;

    logic [LW-1:0]     w_len;
    logic [KW-1:0]     n_buf;
    logic [FW-1:0]     n_fill;
    logic              w_complete;
    logic              w_accept;
    logic              w_cfg_wr;
    logic              w_id_ok;
    logic [NW-1:0]     w_rows_search;
    logic              w_search_done;
    logic              w_learn_wr;
    logic              w_out_free;
    logic              w_emit_last;
    logic [IW-1:0]     w_wr_id;
    t_tok              w_tok_in;
    t_tok              w_tok_out;
    t_ctrl             w_ctrl;
    logic [TOK_W-1:0]  w_chain [N+1];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == kdt_pkg::REG_KMER_LEN);
    assign prdata   = (paddr[2] == kdt_pkg::REG_KMER_LEN)
                    ? kdt_pkg::APB_DW'(r_kmer_len) : '0;

    always_comb begin
        if (r_kmer_len == '0) begin
            w_len = LW'(1);
        end else if (r_kmer_len > LW'(KMER_MAX)) begin
            w_len = LW'(KMER_MAX);
        end else begin
            w_len = r_kmer_len;
        end
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    // Drop the new character into the byte lane selected by the fill count.
    always_comb begin
        n_buf = r_buf;
        for (int i = 0; i < KMER_MAX; i++) begin
            if (r_fill == FW'(i)) begin
                n_buf[8*i +: 8] = r_buf[8*i +: 8] | i_symbol;
            end
        end
        n_fill = (r_fill < FW'(KMER_MAX)) ? r_fill + FW'(1) : r_fill;
    end

    assign w_complete    = (LW'(n_fill) >= w_len) || i_end_of_sequence;
    assign w_id_ok       = !i_token_id[kdt_pkg::TOKEN_W-1]
                        && (XT'(i_token_id[11:0]) < XT'(r_count));
    assign w_rows_search = NW'((SW'(r_count) + SW'(N - 1)) >> CELL_BITS);
    assign w_search_done = (r_inj == r_rows) && (r_done == r_rows);
    assign w_learn_wr    = (r_state == ST_SEARCH) && w_search_done && !r_decode
                        && r_learn && !r_found && (r_count < CW'(VOCAB_DEPTH));
    assign w_out_free    = !r_out_valid || i_ready;
    assign w_emit_last   = !r_decode || (LW'(r_emit_idx) + LW'(1) == w_len);
    assign w_wr_id       = IW'(r_count);

    // Chain input: one vocabulary row per cycle while the search injects.
    always_comb begin
        w_tok_in        = '0;
        w_tok_in.active = (r_state == ST_SEARCH) && (r_inj != r_rows);
        w_tok_in.row    = r_decode ? r_target[IW-1:CELL_BITS] : r_inj[RW-1:0];
    end

    assign w_ctrl.decode = r_decode;
    assign w_ctrl.key    = r_key;
    assign w_ctrl.target = r_target;
    assign w_ctrl.count  = r_count;

    assign w_chain[0] = TOK_W'(w_tok_in);
    assign w_tok_out  = t_tok'(w_chain[N]);

    for (genvar c = 0; c < N; c++) begin : g_cell
        kdt_cell #(
            .CELL_IDX   (c),
            .CELL_BITS  (CELL_BITS),
            .BANK_DEPTH (BANK_DEPTH),
            .RW         (RW),
            .IW         (IW),
            .CW         (CW),
            .KW         (KW),
            .TOK_W      (TOK_W),
            .CTRL_W     (CTRL_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (CTRL_W'(w_ctrl)),
            .i_tok     (w_chain[c]),
            .i_wr_en   (w_learn_wr && (w_wr_id[CELL_BITS-1:0] == CELL_BITS'(c))),
            .i_wr_row  (w_wr_id[IW-1:CELL_BITS]),
            .i_wr_data (r_key),
            .o_tok     (w_chain[c+1])
        );
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len  <= kdt_pkg::KMER_LEN_RESET;
            r_buf       <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_kmer_len <= pwdata[LW-1:0];
            end
            // While emitting, the emit arm below sets the valid flag instead.
            if (r_out_valid && i_ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        unique case (i_op)
                            kdt_pkg::OP_LEARN, kdt_pkg::OP_ENCODE: begin
                                if (w_complete) begin
                                    r_buf   <= '0;
                                    r_fill  <= '0;
                                    r_state <= ST_SEARCH;
                                end else begin
                                    r_buf  <= n_buf;
                                    r_fill <= n_fill;
                                end
                            end
                            kdt_pkg::OP_DECODE: begin
                                r_state <= ST_SEARCH;
                            end
                            kdt_pkg::OP_NONE: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SEARCH: begin
                    if (w_search_done) begin
                        if (w_learn_wr) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= (r_decode || !r_learn) ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (w_emit_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Item data and search bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj  <= '0;
            r_done <= '0;
            r_rows <= '0;
        end else begin
            if (w_accept && (i_op == kdt_pkg::OP_DECODE)) begin
                r_rows <= w_id_ok ? NW'(1) : '0;
                r_inj  <= '0;
                r_done <= '0;
            end else if (w_accept && (i_op != kdt_pkg::OP_NONE) && w_complete) begin
                r_rows <= w_rows_search;
                r_inj  <= '0;
                r_done <= '0;
            end else if (r_state == ST_SEARCH) begin
                if (w_tok_in.active) begin
                    r_inj <= r_inj + NW'(1);
                end
                if (w_tok_out.active) begin
                    r_done <= r_done + NW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_decode   <= (i_op == kdt_pkg::OP_DECODE);
            r_learn    <= (i_op == kdt_pkg::OP_LEARN);
            r_eos      <= i_end_of_sequence;
            r_key      <= n_buf;
            r_target   <= IW'(i_token_id[11:0]);
            r_found    <= 1'b0;
            r_emit_idx <= '0;
        end else if (r_state == ST_SEARCH) begin
            // Rows leave the chain in order, so the first hit has the lowest id.
            if (w_tok_out.active && w_tok_out.found && !r_found) begin
                r_found <= 1'b1;
                r_fid   <= w_tok_out.id;
                r_fdata <= w_tok_out.data;
            end
        end else if ((r_state == ST_EMIT) && w_out_free) begin
            r_emit_idx <= r_emit_idx + FW'(1);
        end
    end

    // Output register load
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && w_out_free) begin
            if (r_decode) begin
                r_out_token_id <= '0;
                r_out_symbol   <= r_found ? kdt_pkg::SYMBOL_W'(r_fdata >> {r_emit_idx, 3'b000})
                                          : kdt_pkg::BAD_CHAR;
                r_out_last     <= w_emit_last;
            end else begin
                r_out_token_id <= r_found ? kdt_pkg::TOKEN_W'(r_fid) : kdt_pkg::UNKNOWN_ID;
                r_out_symbol   <= '0;
                r_out_last     <= r_eos;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_token_id = r_out_token_id;
    assign o_out_symbol   = r_out_symbol;
    assign o_last         = r_out_last;

endmodule
